[rtl/tdsc_pkg.sv]
// Package with shared types and constants of the tachometer speed controller.
package tdsc_pkg;

   localparam logic [15:0] SPEED_NUM = 16'd60000;
   localparam int unsigned DIV_STEPS = 16;
   localparam int unsigned CSR_ADDR_BITS = 5;

   localparam logic [2:0] REG_SET_POINT = 3'd0;
   localparam logic [2:0] REG_DEADBAND  = 3'd1;
   localparam logic [2:0] REG_DUTY_MAX  = 3'd2;
   localparam logic [2:0] REG_PULSES    = 3'd3;
   localparam logic [2:0] REG_INTERVAL  = 3'd4;

   localparam logic [14:0] SET_POINT_RESET = 15'd0;
   localparam logic [9:0]  DEADBAND_RESET  = 10'd10;
   localparam logic [7:0]  DUTY_MAX_RESET  = 8'd100;
   localparam logic [7:0]  PULSES_RESET    = 8'd7;
   localparam logic [15:0] INTERVAL_RESET  = 16'd500;

   typedef struct packed {
      logic [14:0] set_point;
      logic [9:0]  deadband;
      logic [7:0]  duty_max;
      logic [7:0]  pulses_per_measure;
      logic [15:0] control_interval;
   } cfg_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_CTRL
   } state_type;

endpackage

[rtl/tdsc_csr.sv]
// Configuration register file with an APB-style write and read port.
module tdsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tdsc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output tdsc_pkg::cfg_type                   cfg
);

   tdsc_pkg::cfg_type cfg_ff;
   tdsc_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        reg_index;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            tdsc_pkg::REG_SET_POINT: cfg_in.set_point          = csr_pwdata[14:0];
            tdsc_pkg::REG_DEADBAND:  cfg_in.deadband           = csr_pwdata[9:0];
            tdsc_pkg::REG_DUTY_MAX:  cfg_in.duty_max           = csr_pwdata[7:0];
            tdsc_pkg::REG_PULSES:    cfg_in.pulses_per_measure = csr_pwdata[7:0];
            tdsc_pkg::REG_INTERVAL:  cfg_in.control_interval   = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         tdsc_pkg::REG_SET_POINT: csr_prdata = 32'(cfg_ff.set_point);
         tdsc_pkg::REG_DEADBAND:  csr_prdata = 32'(cfg_ff.deadband);
         tdsc_pkg::REG_DUTY_MAX:  csr_prdata = 32'(cfg_ff.duty_max);
         tdsc_pkg::REG_PULSES:    csr_prdata = 32'(cfg_ff.pulses_per_measure);
         tdsc_pkg::REG_INTERVAL:  csr_prdata = 32'(cfg_ff.control_interval);
         default:                 csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_point          <= tdsc_pkg::SET_POINT_RESET;
         cfg_ff.deadband           <= tdsc_pkg::DEADBAND_RESET;
         cfg_ff.duty_max           <= tdsc_pkg::DUTY_MAX_RESET;
         cfg_ff.pulses_per_measure <= tdsc_pkg::PULSES_RESET;
         cfg_ff.control_interval   <= tdsc_pkg::INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/tdsc_div.sv]
// Shift-and-subtract divider that computes the speed constant over the elapsed time.
module tdsc_div #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [TIME_BITS-1:0]    divisor,
   output tdsc_pkg::div_rsp_type   status
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] den_ff, den_in;
   logic [16:0] rem_shift;
   logic [16:0] rem_diff;
   logic        div_zero;
   logic        div_large;

   assign div_zero  = (divisor == '0);
   assign div_large = ((divisor >> 16) != '0);
   assign rem_shift = {rem_ff, quo_ff[15]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         den_in = divisor[15:0];
         rem_in = '0;
         cnt_in = 4'(tdsc_pkg::DIV_STEPS - 1);
         if (div_zero) begin
            quo_in  = tdsc_pkg::SPEED_NUM;
            done_in = 1'b1;
         end else if (div_large) begin
            quo_in  = '0;
            done_in = 1'b1;
         end else begin
            quo_in  = tdsc_pkg::SPEED_NUM;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!rem_diff[16]) begin
            rem_in = rem_diff[15:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = rem_shift[15:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.quotient = quo_ff;

endmodule

[rtl/tachometer_deadband_speed_controller.sv]
// Top level of the tachometer speed meter with deadband step duty control.
// Each item is one millisecond tick and yields exactly one result item. A tick
// without a speed measurement is accepted and then takes a control step before
// the next item can be taken. A tick that completes a measurement first loads the
// shift-and-subtract divider, which then resolves one quotient bit per iteration;
// the quotient is handed over and the control step follows. A zero or very long
// elapsed time skips the iterations. The result sits in an output register, so the
// next item is accepted while an earlier result still waits to be taken, and its
// control step waits until that result is taken.
module tachometer_deadband_speed_controller #(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_edge_seen,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [15:0]                         rsp_speed,
   output logic [7:0]                          rsp_duty,
   output logic                                rsp_speed_updated,
   output logic                                rsp_duty_updated,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tdsc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   tdsc_pkg::cfg_type     cfg;
   tdsc_pkg::div_rsp_type div_status;
   tdsc_pkg::state_type   state_ff, state_in;

   logic [TIME_BITS-1:0] ms_count_ff, ms_count_in;
   logic [TIME_BITS-1:0] last_meas_ff, last_meas_in;
   logic [TIME_BITS-1:0] last_ctrl_ff, last_ctrl_in;
   logic [7:0]           edge_count_ff, edge_count_in;
   logic [15:0]          speed_ff, speed_in;
   logic [7:0]           duty_ff, duty_in;
   logic                 spd_upd_ff, spd_upd_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_speed_ff, rsp_speed_in;
   logic [7:0]           rsp_duty_ff, rsp_duty_in;
   logic                 rsp_spd_upd_ff, rsp_spd_upd_in;
   logic                 rsp_duty_upd_ff, rsp_duty_upd_in;

   logic                 div_start;
   logic [TIME_BITS-1:0] elapsed;
   logic [7:0]           edge_inc;
   logic                 ctrl_due;
   logic                 ctrl_fire;
   logic                 step_up;
   logic                 step_down;
   logic [7:0]           duty_step;
   logic [16:0]          speed_plus_db;
   logic [16:0]          sp_plus_db;

   tdsc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tdsc_div #(
      .TIME_BITS (TIME_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (elapsed),
      .status  (div_status)
   );

   assign elapsed       = ms_count_ff - last_meas_ff;
   assign edge_inc      = edge_count_ff + 8'd1;
   assign ctrl_due      = (ms_count_ff - last_ctrl_ff) >= TIME_BITS'(cfg.control_interval);
   assign speed_plus_db = {1'b0, speed_ff} + 17'(cfg.deadband);
   assign sp_plus_db    = 17'(cfg.set_point) + 17'(cfg.deadband);
   assign step_up       = speed_plus_db < 17'(cfg.set_point);
   assign step_down     = 17'(speed_ff) > sp_plus_db;

   always_comb begin
      duty_step = duty_ff;
      if (step_up) begin
         if (duty_ff < cfg.duty_max) begin
            duty_step = duty_ff + 8'd1;
         end
      end else if (step_down) begin
         if (duty_ff != '0) begin
            duty_step = duty_ff - 8'd1;
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      ms_count_in     = ms_count_ff;
      last_meas_in    = last_meas_ff;
      last_ctrl_in    = last_ctrl_ff;
      edge_count_in   = edge_count_ff;
      speed_in        = speed_ff;
      duty_in         = duty_ff;
      spd_upd_in      = spd_upd_ff;
      rsp_speed_in    = rsp_speed_ff;
      rsp_duty_in     = rsp_duty_ff;
      rsp_spd_upd_in  = rsp_spd_upd_ff;
      rsp_duty_upd_in = rsp_duty_upd_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      div_start       = 1'b0;
      ctrl_fire       = 1'b0;
      req_stall       = 1'b1;
      unique case (state_ff)
         tdsc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               spd_upd_in = 1'b0;
               state_in   = tdsc_pkg::ST_CTRL;
               if (req_edge_seen) begin
                  if (edge_inc >= cfg.pulses_per_measure) begin
                     edge_count_in = '0;
                     last_meas_in  = ms_count_ff;
                     spd_upd_in    = 1'b1;
                     div_start     = 1'b1;
                     state_in      = tdsc_pkg::ST_DIV;
                  end else begin
                     edge_count_in = edge_inc;
                  end
               end
            end
         end
         tdsc_pkg::ST_DIV: begin
            if (div_status.done) begin
               speed_in = div_status.quotient;
               state_in = tdsc_pkg::ST_CTRL;
            end
         end
         tdsc_pkg::ST_CTRL: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctrl_fire = 1'b1;
               if (ctrl_due) begin
                  last_ctrl_in = ms_count_ff;
                  duty_in      = (duty_step > cfg.duty_max) ? cfg.duty_max : duty_step;
               end
               ms_count_in     = ms_count_ff + TIME_BITS'(1);
               rsp_valid_in    = 1'b1;
               rsp_speed_in    = speed_ff;
               rsp_duty_in     = duty_in;
               rsp_spd_upd_in  = spd_upd_ff;
               rsp_duty_upd_in = ctrl_due;
               state_in        = tdsc_pkg::ST_IDLE;
            end
         end
         default: state_in = tdsc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tdsc_pkg::ST_IDLE;
         ms_count_ff   <= '0;
         last_meas_ff  <= '0;
         last_ctrl_ff  <= '0;
         edge_count_ff <= '0;
         speed_ff      <= '0;
         duty_ff       <= '0;
         spd_upd_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ms_count_ff   <= ms_count_in;
         last_meas_ff  <= last_meas_in;
         last_ctrl_ff  <= last_ctrl_in;
         edge_count_ff <= edge_count_in;
         speed_ff      <= speed_in;
         duty_ff       <= duty_in;
         spd_upd_ff    <= spd_upd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_speed_ff    <= rsp_speed_in;
      rsp_duty_ff     <= rsp_duty_in;
      rsp_spd_upd_ff  <= rsp_spd_upd_in;
      rsp_duty_upd_ff <= rsp_duty_upd_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed         = rsp_speed_ff;
   assign rsp_duty          = rsp_duty_ff;
   assign rsp_speed_updated = rsp_spd_upd_ff;
   assign rsp_duty_updated  = rsp_duty_upd_ff;

   a_duty_clamped: assert property (@(posedge clock) disable iff (reset)
      (ctrl_fire && ctrl_due) |-> (duty_in <= cfg.duty_max))
      else $error("duty step left duty above its clamp");

   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_speed_updated) |-> (rsp_speed <= tdsc_pkg::SPEED_NUM))
      else $error("measured speed out of range");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == tdsc_pkg::ST_DIV))
      else $error("divider finished outside a measurement");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdsc_pkg::ST_IDLE) |-> !div_status.busy)
      else $error("divider busy while block is idle");

   a_accept_moves_on: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != tdsc_pkg::ST_IDLE))
      else $error("accepted item was not processed");

endmodule

[tb/tb_tachometer_deadband_speed_controller.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the tachometer speed controller with a built-in predictor.
module tb_tachometer_deadband_speed_controller;

   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned SETTLE_CYCLES = 25;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PHASE_TICKS   = 140;

   typedef struct packed {
      logic [15:0] speed;
      logic [7:0]  duty;
      logic        speed_updated;
      logic        duty_updated;
   } reading_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_edge_seen = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_speed;
   logic [7:0]  rsp_duty;
   logic        rsp_speed_updated;
   logic        rsp_duty_updated;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [tdsc_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tdsc_pkg::cfg_type settings = '{tdsc_pkg::SET_POINT_RESET, tdsc_pkg::DEADBAND_RESET,
                                   tdsc_pkg::DUTY_MAX_RESET, tdsc_pkg::PULSES_RESET,
                                   tdsc_pkg::INTERVAL_RESET};
   logic [31:0] ms_count = '0;
   logic [31:0] last_measure = '0;
   logic [31:0] last_control = '0;
   logic [7:0]  edge_count = '0;
   logic [15:0] speed_value = '0;
   logic [7:0]  duty_value = '0;

   logic        tick_queue[$];
   reading_type expected_readings[$];

   int unsigned tick_gap = 0;
   int unsigned stall_hold = 0;
   logic        sender_steady = 1'b0;
   logic        receiver_steady = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned readings_seen = 0;
   int unsigned measurements_seen = 0;
   int unsigned steps_seen = 0;
   int unsigned settings_applied = 0;

   tachometer_deadband_speed_controller DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_edge_seen(req_edge_seen),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_speed(rsp_speed),
      .rsp_duty(rsp_duty),
      .rsp_speed_updated(rsp_speed_updated),
      .rsp_duty_updated(rsp_duty_updated),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic reading_type advance_controller(input logic edge_bit);
      reading_type r;
      logic [31:0] now;
      logic [31:0] elapsed;
      logic [31:0] quotient;
      int          speed_i;
      int          low_i;
      int          high_i;
      now = ms_count;
      r.speed_updated = 1'b0;
      r.duty_updated = 1'b0;
      if (edge_bit) begin
         edge_count = edge_count + 8'd1;
         if (edge_count >= settings.pulses_per_measure) begin
            elapsed = now - last_measure;
            quotient = (elapsed == 0) ? {16'd0, tdsc_pkg::SPEED_NUM} :
                                        {16'd0, tdsc_pkg::SPEED_NUM} / elapsed;
            edge_count = '0;
            speed_value = quotient[15:0];
            last_measure = now;
            r.speed_updated = 1'b1;
         end
      end
      if (now - last_control >= {16'd0, settings.control_interval}) begin
         speed_i = int'(speed_value);
         low_i = int'(settings.set_point) - int'(settings.deadband);
         high_i = int'(settings.set_point) + int'(settings.deadband);
         last_control = now;
         if (speed_i < low_i) begin
            if (duty_value < settings.duty_max) duty_value = duty_value + 8'd1;
         end else if (speed_i > high_i) begin
            if (duty_value != 0) duty_value = duty_value - 8'd1;
         end
         if (duty_value > settings.duty_max) duty_value = settings.duty_max;
         r.duty_updated = 1'b1;
      end
      ms_count = now + 32'd1;
      r.speed = speed_value;
      r.duty = duty_value;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_edge_seen <= 1'b0;
         tick_gap = 0;
      end else begin
         if (req_valid && !req_stall) expected_readings.push_back(advance_controller(req_edge_seen));
         if (!req_valid || !req_stall) begin
            if (tick_gap > 0) begin
               tick_gap--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
               req_edge_seen <= tick_queue.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 39) == 0) sender_steady = ~sender_steady;
               tick_gap = sender_steady ? 0 : $urandom_range(0, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            readings_seen++;
            if (rsp_speed_updated) measurements_seen++;
            if (rsp_duty_updated) steps_seen++;
            if (expected_readings.size() == 0) begin
               $error("item with no expectation: speed %0d, duty %0d", rsp_speed, rsp_duty);
               error_count++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_speed !== want.speed) begin
                  $error("speed: expected %0d, got %0d", want.speed, rsp_speed);
                  error_count++;
               end
               if (rsp_duty !== want.duty) begin
                  $error("duty: expected %0d, got %0d", want.duty, rsp_duty);
                  error_count++;
               end
               if (rsp_speed_updated !== want.speed_updated) begin
                  $error("speed_updated: expected %0d, got %0d", want.speed_updated,
                         rsp_speed_updated);
                  error_count++;
               end
               if (rsp_duty_updated !== want.duty_updated) begin
                  $error("duty_updated: expected %0d, got %0d", want.duty_updated,
                         rsp_duty_updated);
                  error_count++;
               end
            end
            if ($urandom_range(0, 39) == 0) receiver_steady = ~receiver_steady;
            stall_hold = receiver_steady ? 0 : $urandom_range(0, 19);
         end
         if (stall_hold > 0) begin
            stall_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d items outstanding.", cycle_count,
                  expected_readings.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      unique case (index)
         tdsc_pkg::REG_SET_POINT: settings.set_point = value[14:0];
         tdsc_pkg::REG_DEADBAND:  settings.deadband = value[9:0];
         tdsc_pkg::REG_DUTY_MAX:  settings.duty_max = value[7:0];
         tdsc_pkg::REG_PULSES:    settings.pulses_per_measure = value[7:0];
         tdsc_pkg::REG_INTERVAL:  settings.control_interval = value[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int unsigned set_point, input int unsigned deadband,
                                 input int unsigned duty_max, input int unsigned pulses,
                                 input int unsigned interval);
      write_register(tdsc_pkg::REG_SET_POINT, set_point);
      write_register(tdsc_pkg::REG_DEADBAND, deadband);
      write_register(tdsc_pkg::REG_DUTY_MAX, duty_max);
      write_register(tdsc_pkg::REG_PULSES, pulses);
      write_register(tdsc_pkg::REG_INTERVAL, interval);
      settings_applied++;
      @(negedge clock);
   endtask

   task automatic wait_drained;
      @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_pattern(input int unsigned count, input logic [31:0] bits);
      int i;
      for (i = count - 1; i >= 0; i--) tick_queue.push_back(bits[i]);
   endtask

   task automatic queue_ticks(input int unsigned count);
      int unsigned period;
      int unsigned i;
      logic        edge_bit;
      period = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
      for (i = 0; i < count; i++) begin
         if (period == 0) begin
            edge_bit = 1'($urandom_range(0, 1));
         end else begin
            edge_bit = (i % period) == 0;
            if ($urandom_range(0, 9) == 0) edge_bit = ~edge_bit;
         end
         tick_queue.push_back(edge_bit);
      end
   endtask

   function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                        input int unsigned usual_hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         2: return $urandom_range(lo, hi);
         default: return $urandom_range(lo, usual_hi);
      endcase
   endfunction

   initial begin
      int unsigned phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // A first edge at time zero hits the zero divisor; later duty climbs to its clamp and falls.
      apply_settings(32767, 0, 2, 1, 1);
      queue_pattern(13, 32'b1_1001_0010_0111);
      wait_drained();

      // With the band reaching below zero duty can never step up; edges are counted but too few to measure.
      apply_settings(0, 1023, 1, 255, 3);
      queue_pattern(8, 32'b1111_1100);
      wait_drained();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0) apply_settings(0, 0, 1, 1, 1);
         else if (phase == 1) apply_settings(32767, 1023, 255, 255, 65535);
         else apply_settings(pick(0, 32767, 2000), pick(0, 1023, 50), pick(1, 255, 10),
                             pick(1, 255, 8), pick(1, 65535, 20));
         queue_ticks(PHASE_TICKS);
         wait_drained();
      end

      $display("Checked %0d ticks over %0d register settings.", readings_seen,
               settings_applied);
      $display("They held %0d speed measurements and %0d duty control steps.",
               measurements_seen, steps_seen);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
